### src/sfr_pkg.sv
package sfr_pkg;

    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_OFFSET = 8'd61;
    localparam logic [6:0] MIN_LEN_FLOOR = 7'd5;
    localparam int         GRP_W = 7;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_SHORT     = 3'd2,
        ST_BAD_START = 3'd3,
        ST_BAD_ADDR  = 3'd4,
        ST_RESERVED  = 3'd5,
        ST_LENGTH    = 3'd6,
        ST_CHECKSUM  = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        CFG_MIN_LEN  = 2'd0,
        CFG_RES_ADDR = 2'd1,
        CFG_RES_CMD  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SETTLE,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic [6:0] min_len;
        logic [7:0] res_addr;
        logic [7:0] res_cmd;
    } cfg_t;

    // one closed frame or an overflow event
    typedef struct packed {
        status_t          status;
        logic [7:0]       addr;
        logic [7:0]       cmd;
        logic             walk;
        logic [GRP_W-1:0] groups;
    } job_t;

endpackage

### src/sfr_ram.sv
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/sfr_queue.sv
module sfr_queue
    import sfr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full && !pop |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

### src/sfr_front.sv
module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,
    input  cfg_t                               cfg,
    output logic                               ram_we,
    output logic [$clog2(MAX_FRAME_BYTES)-1:0] ram_waddr,
    output logic [7:0]                         ram_wdata,
    output logic                               push,
    output job_t                               push_job,
    input  logic                               q_full,
    input  logic                               walk_done,
    output logic                               walk_busy
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int LW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_FRAME_BYTES);

    logic [LW-1:0] len_reg, len_next;
    logic [11:0]   sum_reg, sum_next;
    logic [7:0]    b0_reg, b0_next;
    logic [7:0]    b1_reg, b1_next;
    logic [7:0]    b2_reg, b2_next;
    logic [7:0]    last1_reg, last1_next;
    logic [7:0]    last2_reg, last2_next;
    logic          busy_reg, busy_next;

    logic          accept, is_cr, store_byte, overflow, close;
    logic [6:0]    min_len;
    logic [11:0]   cks;
    logic [LW-1:0] plen;
    logic [7:0]    addr;
    logic [7:0]    cks_hi, cks_lo;
    job_t          close_job;

    assign s_tready = !q_full && !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign is_cr    = (s_tdata == CH_CR);
    assign store_byte = accept && !is_cr && (len_reg < LEN_MAX);
    assign overflow = accept && !is_cr && (len_reg >= LEN_MAX);
    assign close    = accept && is_cr && (len_reg != '0);

    // frame checks, evaluated on the terminator beat
    always_comb begin
        min_len = (cfg.min_len < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : cfg.min_len;
        cks     = sum_reg - 12'(last1_reg) - 12'(last2_reg);
        plen    = len_reg - LW'(5);
        addr    = b1_reg - CH_LOWER_A;
        cks_hi  = CH_OFFSET + 8'(cks[11:6]);
        cks_lo  = CH_OFFSET + 8'(cks[5:0]);

        close_job        = '0;
        close_job.status = ST_OK;
        priority if (8'(len_reg) < {1'b0, min_len}) begin
            close_job.status = ST_SHORT;
        end else if (b0_reg != CH_HASH) begin
            close_job.status = ST_BAD_START;
        end else if (b1_reg < CH_LOWER_A || b1_reg[7]) begin
            close_job.status = ST_BAD_ADDR;
        end else if (addr == cfg.res_addr || b2_reg == cfg.res_cmd) begin
            close_job.status = ST_RESERVED;
        end else if (plen[1:0] != 2'b00) begin
            close_job.status = ST_LENGTH;
        end else if (last2_reg != cks_hi || last1_reg != cks_lo) begin
            close_job.status = ST_CHECKSUM;
        end else begin
            close_job.addr   = addr;
            close_job.cmd    = b2_reg;
            close_job.walk   = (plen != '0);
            close_job.groups = GRP_W'(plen >> 2);
        end
    end

    always_comb begin
        push_job = close_job;
        if (overflow) begin
            push_job        = '0;
            push_job.status = ST_OVERFLOW;
        end
    end

    assign push      = overflow || close;
    assign ram_we    = store_byte;
    assign ram_waddr = len_reg[AW-1:0];
    assign ram_wdata = s_tdata;

    always_comb begin
        len_next   = len_reg;
        sum_next   = sum_reg;
        b0_next    = b0_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        last1_next = last1_reg;
        last2_next = last2_reg;
        busy_next  = busy_reg;
        if (store_byte) begin
            len_next   = len_reg + LW'(1);
            sum_next   = (len_reg == '0) ? 12'(s_tdata) : sum_reg + 12'(s_tdata);
            last1_next = s_tdata;
            last2_next = last1_reg;
            if (len_reg == LW'(0)) b0_next = s_tdata;
            if (len_reg == LW'(1)) b1_next = s_tdata;
            if (len_reg == LW'(2)) b2_next = s_tdata;
        end
        if (overflow || close) begin
            len_next = '0;
        end
        if (close && close_job.walk) begin
            busy_next = 1'b1;
        end else if (walk_done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            len_reg  <= len_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg   <= sum_next;
        b0_reg    <= b0_next;
        b1_reg    <= b1_next;
        b2_reg    <= b2_next;
        last1_reg <= last1_next;
        last2_reg <= last2_next;
    end

    assign walk_busy = busy_reg;

endmodule

### src/sfr_back.sv
module sfr_back
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  job_t                               head,
    input  logic                               q_empty,
    output logic                               pop,
    output logic [$clog2(MAX_FRAME_BYTES)-1:0] ram_raddr,
    input  logic [7:0]                         ram_rdata,
    output logic                               walk_done,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    back_state_t      state_reg, state_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [1:0]       sub_reg, sub_next;
    logic [1:0]       idx_reg, idx_next;
    logic [GRP_W-1:0] grp_reg, grp_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic             rd_pend_reg;
    logic [7:0]       ch_reg [4];

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [7:0]       out_addr_reg, out_addr_next;
    logic [7:0]       out_cmd_reg, out_cmd_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_dv_reg, out_dv_next;
    logic             out_last_reg, out_last_next;

    logic             slot_free, load_status, load_data;
    logic [7:0]       sa, sb, sc, sd;
    logic [7:0]       dec [3];

    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        sa = ch_reg[0] - CH_OFFSET;
        sb = ch_reg[1] - CH_OFFSET;
        sc = ch_reg[2] - CH_OFFSET;
        sd = ch_reg[3] - CH_OFFSET;
        dec[0] = {sa[5:0], 2'b00} | {4'b0000, sb[7:4]};
        dec[1] = {sb[3:0], 4'b0000} | {2'b00, sc[7:2]};
        dec[2] = {sc[1:0], 6'b000000} | sd;
    end

    // control outputs
    always_comb begin
        pop         = 1'b0;
        load_status = 1'b0;
        load_data   = 1'b0;
        walk_done   = 1'b0;
        ram_raddr   = ptr_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty && slot_free) begin
                    pop         = 1'b1;
                    load_status = !head.walk;
                end
            end
            B_EMIT: begin
                load_data = slot_free;
                walk_done = slot_free && idx_reg == 2'd2 && grp_reg == GRP_W'(1);
            end
            default: begin
            end
        endcase
    end

    // next state and walk counters
    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        sub_next   = sub_reg;
        idx_next   = idx_reg;
        grp_next   = grp_reg;
        addr_next  = addr_reg;
        cmd_next   = cmd_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (pop && head.walk) begin
                    state_next = B_READ;
                    ptr_next   = AW'(3);
                    sub_next   = 2'd0;
                    idx_next   = 2'd0;
                    grp_next   = head.groups;
                    addr_next  = head.addr;
                    cmd_next   = head.cmd;
                end
            end
            B_READ: begin
                ptr_next = ptr_reg + AW'(1);
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3) state_next = B_SETTLE;
            end
            B_SETTLE: begin
                state_next = B_EMIT;
            end
            B_EMIT: begin
                if (load_data) begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd2) begin
                        idx_next = 2'd0;
                        grp_next = grp_reg - GRP_W'(1);
                        state_next = (grp_reg == GRP_W'(1)) ? B_IDLE : B_READ;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // output register
    always_comb begin
        out_valid_next  = load_status || load_data || (out_valid_reg && !m_tready);
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_cmd_next    = out_cmd_reg;
        out_data_next   = out_data_reg;
        out_dv_next     = out_dv_reg;
        out_last_next   = out_last_reg;
        if (load_status) begin
            out_status_next = head.status;
            out_addr_next   = head.addr;
            out_cmd_next    = head.cmd;
            out_data_next   = 8'd0;
            out_dv_next     = 1'b0;
            out_last_next   = 1'b1;
        end else if (load_data) begin
            out_status_next = ST_OK;
            out_addr_next   = addr_reg;
            out_cmd_next    = cmd_reg;
            out_data_next   = dec[idx_reg];
            out_dv_next     = 1'b1;
            out_last_next   = (idx_reg == 2'd2) && (grp_reg == GRP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_pend_reg   <= (state_reg == B_READ);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg        <= ptr_next;
        sub_reg        <= sub_next;
        idx_reg        <= idx_next;
        grp_reg        <= grp_next;
        addr_reg       <= addr_next;
        cmd_reg        <= cmd_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_cmd_reg    <= out_cmd_next;
        out_data_reg   <= out_data_next;
        out_dv_reg     <= out_dv_next;
        out_last_reg   <= out_last_next;
        if (rd_pend_reg) begin
            ch_reg[0] <= ch_reg[1];
            ch_reg[1] <= ch_reg[2];
            ch_reg[2] <= ch_reg[3];
            ch_reg[3] <= ram_rdata;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_data_reg, out_cmd_reg, out_addr_reg, out_status_reg};
    assign m_tuser  = out_dv_reg;
    assign m_tlast  = out_last_reg;

endmodule

### src/serial_frame_receiver.sv
// channel   dir  tdata fields (low bit up)                      tuser       tlast
// s_*       in   rx_byte[7:0]                                   -           -
// m_*       out  status[2:0] frame_address[10:3]                data_valid  last_item
//                frame_command[18:11] data_byte[26:19]
// cfg_*     in   index 0 min_frame_length, 1 reserved_address, 2 reserved_command
//
// A taken byte other than the terminator is written to the frame store if it fits.
// A terminator after a non-empty frame, or an overflow byte, queues one job.
// A good payload is read back four characters per group over the single RAM read
// port and decoded into three output beats per group, the input held off meanwhile.
// Synchronous active-low reset; the frame store needs no clearing.
// Output stalls back up through a two-entry job queue to s_tready.
module serial_frame_receiver
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status, frame_address, frame_command, data_byte
    output logic        m_tuser,   // data_valid
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    cfg_t          cfg_reg, cfg_next;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic          push, pop, q_empty, q_full;
    job_t          push_job, head;
    logic          walk_done, walk_busy;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_MIN_LEN:  cfg_next.min_len  = cfg_wdata[6:0];
                CFG_RES_ADDR: cfg_next.res_addr = cfg_wdata;
                CFG_RES_CMD:  cfg_next.res_cmd  = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_len  <= MIN_LEN_FLOOR;
            cfg_reg.res_addr <= 8'd0;
            cfg_reg.res_cmd  <= 8'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sfr_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg       (cfg_reg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .push      (push),
        .push_job  (push_job),
        .q_full    (q_full),
        .walk_done (walk_done),
        .walk_busy (walk_busy)
    );

    sfr_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_BYTES)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sfr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    sfr_back #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .walk_done (walk_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTH
    a_no_rx_during_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_busy |-> !s_tready)
        else $error("byte taken while payload walk in progress");
    a_status_beat_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("status beat without last");
    a_error_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_OK |-> !m_tuser && m_tdata[26:3] == 24'd0)
        else $error("error beat carries frame fields");
`endif

endmodule

### dv/tb_top.sv
module tb_top;
    import sfr_pkg::*;

    localparam int FRAME_CAP     = 64;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [1:0] CFG_NONE = 2'd3;

    typedef struct packed {
        status_t    status;
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [7:0] data;
        logic       valid;
        logic       last;
    } rx_beat_t;

    typedef enum logic [2:0] {FL_NONE, FL_EMPTY, FL_SHORT, FL_START, FL_CKSUM} flaw_t;
    typedef enum logic [1:0] {PF_RAND, PF_ZERO, PF_ONES} fill_t;
    typedef enum logic {RK_FRAME, RK_CFG} row_kind_t;

    // frame rows: a = address char, b = command; config rows: a = index, b = value
    typedef struct packed {
        row_kind_t  kind;
        flaw_t      flaw;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] npay;
        fill_t      fill;
        logic       typed;
        status_t    st;
    } row_t;

    localparam row_t PLAN [25] = '{
        '{RK_FRAME, FL_EMPTY, 8'h00, 8'h00, 8'd0,  PF_RAND, 1'b0, ST_OK},
        '{RK_FRAME, FL_SHORT, 8'h62, 8'h01, 8'd0,  PF_RAND, 1'b1, ST_SHORT},
        '{RK_FRAME, FL_START, 8'h62, 8'h01, 8'd0,  PF_RAND, 1'b1, ST_BAD_START},
        '{RK_FRAME, FL_NONE,  8'h60, 8'h01, 8'd0,  PF_RAND, 1'b1, ST_BAD_ADDR},
        '{RK_FRAME, FL_NONE,  8'h80, 8'h01, 8'd0,  PF_RAND, 1'b1, ST_BAD_ADDR},
        '{RK_FRAME, FL_NONE,  8'hff, 8'h01, 8'd0,  PF_RAND, 1'b1, ST_BAD_ADDR},
        '{RK_FRAME, FL_NONE,  8'h61, 8'h05, 8'd0,  PF_RAND, 1'b1, ST_RESERVED},
        '{RK_FRAME, FL_NONE,  8'h63, 8'h00, 8'd0,  PF_RAND, 1'b1, ST_RESERVED},
        '{RK_FRAME, FL_NONE,  8'h62, 8'h01, 8'd3,  PF_RAND, 1'b1, ST_LENGTH},
        '{RK_FRAME, FL_CKSUM, 8'h62, 8'h01, 8'd4,  PF_RAND, 1'b1, ST_CHECKSUM},
        '{RK_FRAME, FL_NONE,  8'h7a, 8'hff, 8'd0,  PF_RAND, 1'b0, ST_OK},
        '{RK_FRAME, FL_NONE,  8'h7f, 8'hff, 8'd4,  PF_ZERO, 1'b0, ST_OK},
        '{RK_FRAME, FL_NONE,  8'h62, 8'h80, 8'd8,  PF_ONES, 1'b0, ST_OK},
        '{RK_FRAME, FL_NONE,  8'h64, 8'h2a, 8'd56, PF_RAND, 1'b0, ST_OK},
        '{RK_FRAME, FL_NONE,  8'h64, 8'h2a, 8'd59, PF_RAND, 1'b1, ST_LENGTH},
        '{RK_FRAME, FL_NONE,  8'h64, 8'h2a, 8'd60, PF_RAND, 1'b1, ST_OVERFLOW},
        '{RK_CFG,   FL_NONE,  8'(CFG_MIN_LEN),  8'h00, 8'd0, PF_RAND, 1'b0, ST_OK},
        '{RK_FRAME, FL_NONE,  8'h62, 8'h01, 8'd0,  PF_RAND, 1'b0, ST_OK},
        '{RK_CFG,   FL_NONE,  8'(CFG_MIN_LEN),  8'h7f, 8'd0, PF_RAND, 1'b0, ST_OK},
        '{RK_FRAME, FL_NONE,  8'h62, 8'h01, 8'd4,  PF_RAND, 1'b1, ST_SHORT},
        '{RK_CFG,   FL_NONE,  8'(CFG_RES_ADDR), 8'hff, 8'd0, PF_RAND, 1'b0, ST_OK},
        '{RK_CFG,   FL_NONE,  8'(CFG_RES_CMD),  8'hff, 8'd0, PF_RAND, 1'b0, ST_OK},
        '{RK_CFG,   FL_NONE,  8'(CFG_NONE),     8'haa, 8'd0, PF_RAND, 1'b0, ST_OK},
        '{RK_CFG,   FL_NONE,  8'(CFG_MIN_LEN),  8'h05, 8'd0, PF_RAND, 1'b0, ST_OK},
        '{RK_FRAME, FL_NONE,  8'h61, 8'h00, 8'd4,  PF_RAND, 1'b0, ST_OK}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_wdata = 8'h00;

    logic [7:0] frame_mem [FRAME_CAP];
    int         frame_len = 0;
    logic [6:0] min_len_r = MIN_LEN_FLOOR;
    logic [7:0] res_addr_r = 8'h00;
    logic [7:0] res_cmd_r = 8'h00;

    rx_beat_t   pending_beats [$];
    rx_beat_t   fresh_beats [$];
    rx_beat_t   want_beat;
    logic [7:0] frame_bytes [$];
    int         bytes_sent = 0;
    int         mismatches = 0;
    int         src_idle = 0;
    int         snk_idle = 0;

    serial_frame_receiver #(.MAX_FRAME_BYTES(FRAME_CAP)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle);
    end

    function automatic void add_fresh(rx_beat_t bt);
        fresh_beats.insert(fresh_beats.size(), bt);
    endfunction

    function automatic void add_pending(rx_beat_t bt);
        pending_beats.insert(pending_beats.size(), bt);
    endfunction

    function automatic void add_frame_byte(logic [7:0] b);
        frame_bytes.insert(frame_bytes.size(), b);
    endfunction

    function automatic void status_beat(status_t st);
        add_fresh('{st, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1});
    endfunction

    function automatic void judge_frame();
        int         minlen;
        int         plen;
        int         sum;
        logic [7:0] addr, cmd, a, b, c, d;
        logic [7:0] v [3];
        minlen = (min_len_r < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len_r;
        plen = frame_len - 5;
        addr = frame_mem[1] - CH_LOWER_A;
        cmd = frame_mem[2];
        sum = 0;
        for (int i = 0; i < frame_len - 2; i++) sum += frame_mem[i];
        if (frame_len < minlen) status_beat(ST_SHORT);
        else if (frame_mem[0] != CH_HASH) status_beat(ST_BAD_START);
        else if (frame_mem[1] < CH_LOWER_A || frame_mem[1][7]) status_beat(ST_BAD_ADDR);
        else if (addr == res_addr_r || cmd == res_cmd_r) status_beat(ST_RESERVED);
        else if (plen[1:0] != 2'd0) status_beat(ST_LENGTH);
        else if (frame_mem[frame_len-2] != CH_OFFSET + 8'(sum[11:6]) ||
                 frame_mem[frame_len-1] != CH_OFFSET + 8'(sum[5:0])) status_beat(ST_CHECKSUM);
        else if (plen == 0) add_fresh('{ST_OK, addr, cmd, 8'h00, 1'b0, 1'b1});
        else begin
            for (int g = 0; g < plen; g += 4) begin
                a = frame_mem[3+g] - CH_OFFSET;
                b = frame_mem[4+g] - CH_OFFSET;
                c = frame_mem[5+g] - CH_OFFSET;
                d = frame_mem[6+g] - CH_OFFSET;
                v[0] = (a << 2) | (b >> 4);
                v[1] = ((b & 8'h0f) << 4) | (c >> 2);
                v[2] = ((c & 8'h03) << 6) | d;
                for (int j = 0; j < 3; j++)
                    add_fresh('{ST_OK, addr, cmd, v[j], 1'b1,
                                (g + 4 == plen) && (j == 2)});
            end
        end
    endfunction

    function automatic void absorb_byte(logic [7:0] c);
        if (c == CH_CR) begin
            if (frame_len != 0) judge_frame();
            frame_len = 0;
        end else if (frame_len >= FRAME_CAP) begin
            frame_len = 0;
            status_beat(ST_OVERFLOW);
        end else begin
            frame_mem[frame_len] = c;
            frame_len++;
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] r;
        do r = 8'($urandom_range(0, 255)); while (r == CH_CR);
        return r;
    endfunction

    function automatic void build_frame(flaw_t flaw, logic [7:0] ach, logic [7:0] cmd,
                                        int npay, fill_t fill);
        int         sum;
        logic [7:0] b;
        frame_bytes.delete();
        if (flaw != FL_EMPTY) begin
            b = CH_HASH;
            if (flaw == FL_START) begin
                do b = pick_byte(); while (b == CH_HASH);
            end
            add_frame_byte(b);
            add_frame_byte(ach);
            add_frame_byte(cmd);
            if (flaw != FL_SHORT) begin
                for (int i = 0; i < npay; i++)
                    add_frame_byte(fill == PF_ZERO ? 8'h00 :
                                   fill == PF_ONES ? 8'hff : pick_byte());
                sum = 0;
                foreach (frame_bytes[i]) sum += frame_bytes[i];
                add_frame_byte(CH_OFFSET + 8'(sum[11:6]));
                add_frame_byte(CH_OFFSET + 8'(sum[5:0]) + 8'(flaw == FL_CKSUM));
            end
        end
        add_frame_byte(CH_CR);
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                flag_mismatch("unexpected beat", m_tdata, 32'h0);
            end else begin
                want_beat = pending_beats[0];
                pending_beats.delete(0);
                if (m_tdata[2:0] !== want_beat.status)
                    flag_mismatch("status", m_tdata[2:0], want_beat.status);
                if (m_tdata[10:3] !== want_beat.addr)
                    flag_mismatch("frame_address", m_tdata[10:3], want_beat.addr);
                if (m_tdata[18:11] !== want_beat.cmd)
                    flag_mismatch("frame_command", m_tdata[18:11], want_beat.cmd);
                if (m_tdata[26:19] !== want_beat.data)
                    flag_mismatch("data_byte", m_tdata[26:19], want_beat.data);
                if (m_tdata[31:27] !== 5'd0)
                    flag_mismatch("tdata pad", m_tdata[31:27], 32'h0);
                if (m_tuser !== want_beat.valid)
                    flag_mismatch("data_valid", m_tuser, want_beat.valid);
                if (m_tlast !== want_beat.last)
                    flag_mismatch("last_item", m_tlast, want_beat.last);
            end
        end
    end

    // typed rows replace the predicted beat with the status read off the row
    task automatic push_byte(logic [7:0] b, logic typed, status_t st);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        fresh_beats.delete();
        absorb_byte(b);
        if (typed && fresh_beats.size() != 0)
            add_pending('{st, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1});
        else
            foreach (fresh_beats[k]) add_pending(fresh_beats[k]);
        bytes_sent++;
    endtask

    task automatic send_frame(logic typed, status_t st);
        foreach (frame_bytes[i]) push_byte(frame_bytes[i], typed, st);
    endtask

    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        wait_quiet();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        unique case (idx)
            CFG_MIN_LEN:  min_len_r = val[6:0];
            CFG_RES_ADDR: res_addr_r = val;
            CFG_RES_CMD:  res_cmd_r = val;
            default: ;
        endcase
    endtask

    task automatic random_traffic(int nbytes);
        int         goal;
        int         r;
        int         npay;
        logic [7:0] ach;
        logic [7:0] cmd;
        flaw_t      flaw;
        goal = bytes_sent + nbytes;
        while (bytes_sent < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)), 1'b0, ST_OK);
                push_byte(CH_CR, 1'b0, ST_OK);
            end else begin
                r = $urandom_range(0, 99);
                flaw = (r < 70) ? FL_NONE : flaw_t'($urandom_range(1, 4));
                r = $urandom_range(0, 99);
                ach = (r < 15) ? pick_byte() :
                      (r < 25) ? CH_LOWER_A + res_addr_r :
                                 8'($urandom_range(CH_LOWER_A, 8'h7f));
                cmd = ($urandom_range(0, 9) == 0) ? res_cmd_r : pick_byte();
                r = $urandom_range(0, 99);
                if (r < 70) npay = 4 * $urandom_range(0, 4);
                else if (r < 80) npay = 4 * $urandom_range(5, 14);
                else if (r < 90) npay = $urandom_range(0, 63);
                else npay = 4 * $urandom_range(0, 3) + $urandom_range(1, 3);
                build_frame(flaw, ach, cmd, npay, PF_RAND);
                send_frame(1'b0, ST_OK);
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_idle = 15;
        snk_idle = 88;
        foreach (PLAN[r]) begin
            if (PLAN[r].kind == RK_CFG) begin
                write_reg(PLAN[r].a[1:0], PLAN[r].b);
            end else begin
                build_frame(PLAN[r].flaw, PLAN[r].a, PLAN[r].b, PLAN[r].npay, PLAN[r].fill);
                send_frame(PLAN[r].typed, PLAN[r].st);
            end
        end

        write_reg(CFG_MIN_LEN, 8'($urandom_range(5, 12)));
        write_reg(CFG_RES_ADDR, 8'($urandom_range(0, 30)));
        write_reg(CFG_RES_CMD, 8'($urandom_range(0, 255)));
        random_traffic(6);

        write_reg(CFG_MIN_LEN, 8'h00);
        write_reg(CFG_RES_ADDR, 8'd30);
        write_reg(CFG_RES_CMD, 8'hff);
        src_idle = 88;
        snk_idle = 15;
        random_traffic(6);

        write_reg(CFG_MIN_LEN, 8'($urandom_range(5, 16)));
        write_reg(CFG_RES_ADDR, 8'($urandom_range(0, 255)));
        write_reg(CFG_RES_CMD, 8'($urandom_range(0, 255)));
        src_idle = 0;
        snk_idle = 0;
        random_traffic(6);

        wait_quiet();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
src/sfr_pkg.sv
src/sfr_ram.sv
src/sfr_queue.sv
src/sfr_front.sv
src/sfr_back.sv
src/serial_frame_receiver.sv
dv/tb_top.sv
